FILE: src/sut_pkg.sv
`timescale 1ns / 1ps

package sut_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 31;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_INSERT = 3'd0;
  localparam cmd_t CMD_REMOVE = 3'd1;
  localparam cmd_t CMD_POPMAX = 3'd2;
  localparam cmd_t CMD_POPMIN = 3'd3;
  localparam cmd_t CMD_READ   = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_MISS  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  typedef struct packed {
    cmd_t             cmd;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
    logic [6:0]         count;
  } out_item_t;

  // one read and one write port per cycle
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: src/sut_mem.sv
`timescale 1ns / 1ps

module sut_mem (
  input  logic                         clk,
  input  sut_pkg::mem_req_t            req,
  output logic [sut_pkg::VAL_W-1:0]    rdata
);
  import sut_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/sut_cmp.sv
`timescale 1ns / 1ps

module sut_cmp (
  input  logic [sut_pkg::VAL_W-1:0] a,
  input  logic [sut_pkg::VAL_W-1:0] b,
  output sut_pkg::cmp_res_t         res
);
  import sut_pkg::*;

  assign res.gt = (a > b);
  assign res.eq = (a == b);

endmodule

FILE: src/sut_seq.sv
`timescale 1ns / 1ps

module sut_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  sut_pkg::in_item_t            in_item,
  output logic                         busy,
  output sut_pkg::mem_req_t            mem_req,
  input  logic [sut_pkg::VAL_W-1:0]    rdata,
  output logic                         done,
  output sut_pkg::out_item_t           res
);
  import sut_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SHUP, S_WRV, S_DROP, S_FRD0, S_FRD1, S_FOUT
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             chk_r, chk_nxt;
  logic             wpend_r, wpend_nxt;
  logic [IDX_W-1:0] wadr_r, wadr_nxt;
  status_t          status_r, status_nxt;
  logic [VAL_W-1:0] max_r, max_nxt;

  cmp_res_t         cmp;
  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] hit_pos;
  logic             hit, scan_end, hit_eq;

  sut_cmp u_cmp (
    .a   (rdata),
    .b   (val_r),
    .res (cmp)
  );

  assign idx_m1 = idx_r - 1'b1;
  assign idx_p1 = idx_r + 1'b1;
  assign cnt_m1 = cnt_r - 1'b1;

  // scan stops at the first entry not greater than the key
  assign hit      = chk_r && !cmp.gt;
  assign scan_end = hit || (idx_r == cnt_r);
  assign hit_pos  = hit ? idx_m1 : cnt_r;
  assign hit_eq   = hit && cmp.eq;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    chk_nxt    = chk_r;
    wpend_nxt  = wpend_r;
    wadr_nxt   = wadr_r;
    status_nxt = status_r;
    max_nxt    = max_r;
    mem_req    = '0;
    done       = 1'b0;
    res        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_item.cmd;
          val_nxt    = in_item.value;
          idx_nxt    = '0;
          chk_nxt    = 1'b0;
          wpend_nxt  = 1'b0;
          status_nxt = ST_DONE;
          case (in_item.cmd)
            CMD_INSERT: state_nxt = S_SRCH;
            CMD_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FRD0;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            CMD_POPMAX: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FRD0;
              end else begin
                pos_nxt   = '0;
                idx_nxt   = CNT_W'(1);
                state_nxt = S_DROP;
              end
            end
            CMD_POPMIN: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
              state_nxt = S_FRD0;
            end
            default: state_nxt = S_FRD0;
          endcase
        end
      end

      S_SRCH: begin
        if (scan_end) begin
          chk_nxt   = 1'b0;
          wpend_nxt = 1'b0;
          if (cmd_r == CMD_INSERT) begin
            if (hit_eq) begin
              status_nxt = ST_MISS;
              state_nxt  = S_FRD0;
            end else if (cnt_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FRD0;
            end else begin
              pos_nxt   = hit_pos;
              idx_nxt   = cnt_r;
              state_nxt = S_SHUP;
            end
          end else begin
            if (!hit_eq) begin
              status_nxt = ST_MISS;
              state_nxt  = S_FRD0;
            end else begin
              pos_nxt   = hit_pos;
              idx_nxt   = idx_r;
              state_nxt = S_DROP;
            end
          end
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r[IDX_W-1:0];
          idx_nxt       = idx_p1;
          chk_nxt       = 1'b1;
        end
      end

      // move entries one slot down the list, last one first
      S_SHUP: begin
        mem_req.we    = wpend_r;
        mem_req.waddr = wadr_r;
        mem_req.wdata = rdata;
        if (idx_r == pos_r) begin
          wpend_nxt = 1'b0;
          state_nxt = S_WRV;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_m1[IDX_W-1:0];
          wadr_nxt      = idx_r[IDX_W-1:0];
          idx_nxt       = idx_m1;
          wpend_nxt     = 1'b1;
        end
      end

      S_WRV: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r[IDX_W-1:0];
        mem_req.wdata = val_r;
        cnt_nxt       = cnt_r + 1'b1;
        state_nxt     = S_FRD0;
      end

      // close the gap at pos, first one first
      S_DROP: begin
        mem_req.we    = wpend_r;
        mem_req.waddr = wadr_r;
        mem_req.wdata = rdata;
        if (idx_r == cnt_r) begin
          wpend_nxt = 1'b0;
          cnt_nxt   = cnt_m1;
          state_nxt = S_FRD0;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r[IDX_W-1:0];
          wadr_nxt      = idx_m1[IDX_W-1:0];
          idx_nxt       = idx_p1;
          wpend_nxt     = 1'b1;
        end
      end

      S_FRD0: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
        state_nxt     = S_FRD1;
      end

      S_FRD1: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cnt_m1[IDX_W-1:0];
        max_nxt       = rdata;
        state_nxt     = S_FOUT;
      end

      S_FOUT: begin
        done       = 1'b1;
        res.status = status_r;
        res.count  = 7'(cnt_r);
        if (cnt_r == '0) begin
          res.max_value = '1;
          res.min_value = '1;
        end else begin
          res.max_value = {1'b0, max_r};
          res.min_value = {1'b0, rdata};
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      chk_r   <= 1'b0;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chk_r   <= chk_nxt;
      wpend_r <= wpend_nxt;
    end
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    wadr_r   <= wadr_nxt;
    status_r <= status_nxt;
    max_r    <= max_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: src/sorted_unique_set_table.sv
// Channel   Ports                      Transfer
// command   start, busy, in_item       start && !busy at a rising edge
// result    out_valid, out_item        out_valid for one cycle, always taken
//
// Per command: insert and remove-value scan one entry per cycle, then
// shift one entry per cycle through the entry RAM, one read and one write
// per cycle; remove-largest shifts without a scan; the rest only read
// the two end slots.
// Reset: synchronous active-low rst_n empties the set; RAM contents are
// left as they are and only slots below the count ever reach a result.
// Result appears in the first cycle with busy low; a new command may be
// issued in that same cycle. The receiver has no way to stall.
`timescale 1ns / 1ps

module sorted_unique_set_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sut_pkg::in_item_t  in_item,
  output logic               out_valid,
  output sut_pkg::out_item_t out_item
);
  import sut_pkg::*;

  mem_req_t         mem_req;
  logic [VAL_W-1:0] rdata;
  logic             seq_done;
  out_item_t        seq_res;

  logic             out_valid_r;
  out_item_t        out_item_r;

  // sequencer: scan, shift and summary read, all through one RAM port pair
  sut_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .mem_req (mem_req),
    .rdata   (rdata),
    .done    (seq_done),
    .res     (seq_res)
  );

  // entries held in descending order, slot 0 is the largest
  sut_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // output register: result shown one cycle, sequencer already idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= seq_done;
    end
    if (seq_done) begin
      out_item_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a transfer on the command side always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command transfer did not start the sequencer");

  // a result only follows the end of a command
  a_res_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a finished command");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.count <= 7'(CAPACITY)))
    else $error("count beyond capacity");

  a_empty_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.count == '0) |->
      (out_item.max_value == -32'sd1 && out_item.min_value == -32'sd1))
    else $error("empty set must report -1");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.count != '0) |->
      (out_item.max_value >= out_item.min_value && out_item.min_value >= 0))
    else $error("max below min");

endmodule
